// File: rtl/dqe_pkg.sv
// shared types and constants for the double-ended queue
package dqe_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 64;
  localparam int WORD_W         = 64;
  localparam int COUNT_W        = 5;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_PEEK_FRONT = 3'd4,
    OP_PEEK_BACK  = 3'd5,
    OP_REVERSE    = 3'd6,
    OP_CLEAR      = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    op_t               op;
    logic [WORD_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [WORD_W-1:0]  data;
    status_t            status;
    logic [COUNT_W-1:0] count;
  } rsp_t;

  // result info that travels beside the ram read data
  typedef struct packed {
    logic               rd;
    status_t            status;
    logic [COUNT_W-1:0] count;
  } meta_t;

endpackage

// File: rtl/dqe_ram.sv
// generic single-port ram with registered read
module dqe_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// File: rtl/dqe_ctrl.sv
// ring pointer state, operation decode and ram access
module dqe_ctrl import dqe_pkg::*; #(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     take,
  input  req_t                     req,
  output logic                     ram_we,
  output logic                     ram_re,
  output logic [$clog2(DEPTH)-1:0] ram_addr,
  output logic [DATA_WIDTH-1:0]    ram_wdata,
  output meta_t                    meta
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = AW + 1;

  logic [AW-1:0] head, head_next;
  logic [CW-1:0] count, count_next;
  logic          reversed, reversed_next;

  logic          at_front, phys_front, full, empty;
  logic [SW-1:0] tail_sum, back_sum;
  logic [AW-1:0] tail_idx, back_idx, prev_head, succ_head;
  logic          we, re, rd;
  status_t       status;
  logic [AW-1:0] addr;

  assign at_front   = (req.op == OP_PUSH_FRONT) || (req.op == OP_POP_FRONT) ||
                      (req.op == OP_PEEK_FRONT);
  assign phys_front = at_front ^ reversed;
  assign full       = (count == CW'(DEPTH));
  assign empty      = (count == '0);

  // ring positions; while the queue holds a word, each sum stays below twice the depth
  assign tail_sum  = SW'(head) + SW'(count);
  assign back_sum  = tail_sum - SW'(1);
  assign tail_idx  = (tail_sum >= SW'(DEPTH)) ? AW'(tail_sum - SW'(DEPTH)) : AW'(tail_sum);
  assign back_idx  = (back_sum >= SW'(DEPTH)) ? AW'(back_sum - SW'(DEPTH)) : AW'(back_sum);
  assign prev_head = (head == '0) ? AW'(DEPTH - 1) : head - AW'(1);
  assign succ_head = (head == AW'(DEPTH - 1)) ? '0 : head + AW'(1);

  always_comb begin
    head_next     = head;
    count_next    = count;
    reversed_next = reversed;
    we            = 1'b0;
    re            = 1'b0;
    rd            = 1'b0;
    status        = ST_OK;
    addr          = phys_front ? head : back_idx;
    unique case (req.op)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        addr = phys_front ? prev_head : tail_idx;
        if (full) begin
          status = ST_FULL;
        end else begin
          we         = 1'b1;
          count_next = count + CW'(1);
          if (phys_front) begin
            head_next = prev_head;
          end
        end
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          re         = 1'b1;
          rd         = 1'b1;
          count_next = count - CW'(1);
          if (phys_front) begin
            head_next = succ_head;
          end
        end
      end
      OP_PEEK_FRONT, OP_PEEK_BACK: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          re = 1'b1;
          rd = 1'b1;
        end
      end
      OP_REVERSE: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          reversed_next = !reversed;
        end
      end
      OP_CLEAR: begin
        head_next     = '0;
        count_next    = '0;
        reversed_next = 1'b0;
      end
    endcase
  end

  assign ram_we    = take && we;
  assign ram_re    = take && re;
  assign ram_addr  = addr;
  assign ram_wdata = req.value[DATA_WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      count    <= '0;
      reversed <= 1'b0;
    end else if (take) begin
      head     <= head_next;
      count    <= count_next;
      reversed <= reversed_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      meta.rd     <= rd;
      meta.status <= status;
      meta.count  <= COUNT_W'(count_next);
    end
  end

endmodule

// File: rtl/dqe_out.sv
// result stage beside the ram read register and the output register
module dqe_out import dqe_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  take,
  input  meta_t                 meta,
  input  logic [DATA_WIDTH-1:0] ram_rdata,
  input  logic                  rsp_stall,
  output logic                  rsp_valid,
  output rsp_t                  rsp,
  output logic                  open
);

  logic mid_valid;
  logic load;

  assign load = mid_valid && (!rsp_valid || !rsp_stall);
  assign open = !mid_valid || load;

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (take) begin
        mid_valid <= 1'b1;
      end else if (load) begin
        mid_valid <= 1'b0;
      end
      if (load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rsp.data   <= meta.rd ? WORD_W'(ram_rdata) : '0;
      rsp.status <= meta.status;
      rsp.count  <= meta.count;
    end
  end

endmodule

// File: rtl/double_ended_queue_core.sv
// double-ended queue core: ring store with head pointer, fill count and direction flag
// path: a result is registered beside the ram read data in the middle stage, then moves
// into the output register, which holds it while the response is stalled
// throughput: one word per cycle unless stalled; single ram port, <= one access per word
// reset: head, count and direction clear at once; the store keeps its contents
// and is only read at entries a push has written
module double_ended_queue_core import dqe_pkg::*; #(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst,
  // request channel
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  // response channel
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  localparam int AW = $clog2(DEPTH);

  logic                  take;
  logic                  open;
  logic                  ram_we;
  logic                  ram_re;
  logic [AW-1:0]         ram_addr;
  logic [DATA_WIDTH-1:0] ram_wdata;
  logic [DATA_WIDTH-1:0] ram_rdata;
  meta_t                 meta;

  // a word enters whenever the middle stage is empty or moving on
  assign req_stall = !open;
  assign take      = req_valid && open;

  // pointer state and decode; updates state and drives the ram on the accept edge
  dqe_ctrl #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .req       (req),
    .ram_we    (ram_we),
    .ram_re    (ram_re),
    .ram_addr  (ram_addr),
    .ram_wdata (ram_wdata),
    .meta      (meta)
  );

  // ring store; read data holds until the next read so a stalled result keeps it
  dqe_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // output register; the response stall reaches the request stall combinationally
  dqe_out #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_out (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .meta      (meta),
    .ram_rdata (ram_rdata),
    .rsp_stall (rsp_stall),
    .rsp_valid (rsp_valid),
    .rsp       (rsp),
    .open      (open)
  );

endmodule
